// ===== rtl/svwd_pkg.sv =====
// ----------------------------------------------------------------------------
// svwd_pkg
// Shared types, constants and the debounce counter step for the supply
// voltage window debounce unit.
// ----------------------------------------------------------------------------
`default_nettype none

package svwd_pkg;

   // ADC sample width and debounce counter width
   localparam int SAMPLE_BITS   = 12;
   localparam int CNT_BITS      = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = (SAMPLE_BITS > CNT_BITS) ? SAMPLE_BITS : CNT_BITS;

   typedef logic [SAMPLE_BITS-1:0]   sample_type;
   typedef logic [CNT_BITS-1:0]      cnt_type;
   typedef logic [CSR_IDX_BITS-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   // Register indexes on the CSR port
   localparam csr_idx_type CSR_OVER_THRESHOLD  = csr_idx_type'(0);
   localparam csr_idx_type CSR_OVER_RELEASE    = csr_idx_type'(1);
   localparam csr_idx_type CSR_UNDER_THRESHOLD = csr_idx_type'(2);
   localparam csr_idx_type CSR_UNDER_RELEASE   = csr_idx_type'(3);
   localparam csr_idx_type CSR_OVER_COUNT      = csr_idx_type'(4);
   localparam csr_idx_type CSR_UNDER_COUNT     = csr_idx_type'(5);

   // Register reset values
   localparam sample_type RST_OVER_THRESHOLD  = sample_type'(3500);
   localparam sample_type RST_OVER_RELEASE    = sample_type'(3300);
   localparam sample_type RST_UNDER_THRESHOLD = sample_type'(1500);
   localparam sample_type RST_UNDER_RELEASE   = sample_type'(1700);
   localparam cnt_type    RST_OVER_COUNT      = cnt_type'(10);
   localparam cnt_type    RST_UNDER_COUNT     = cnt_type'(10);

   localparam cnt_type CNT_MAX = '1;

   typedef enum logic [1:0] {
      REP_NONE   = 2'd0,
      REP_FAILED = 2'd1,
      REP_PASSED = 2'd2
   } report_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_ENTERED = 2'd1,
      EV_LEFT    = 2'd2
   } event_type;

   // Input beat
   typedef struct packed {
      logic       command;
      sample_type sample;
      logic       monitor_enable;
      logic       under_fault_active;
      logic       over_fault_active;
   } req_type;

   // Result beat
   typedef struct packed {
      report_type over_report;
      report_type under_report;
      event_type  over_event;
      event_type  under_event;
   } rsp_type;

   // Configuration registers as seen by the evaluation logic
   typedef struct packed {
      sample_type over_threshold;
      sample_type over_release;
      sample_type under_threshold;
      sample_type under_release;
      cnt_type    over_count;
      cnt_type    under_count;
   } cfg_type;

   typedef struct packed {
      cnt_type cnt;
      logic    fire;
   } step_type;

   // Saturating counter step: fires when the new value hits the limit,
   // clamps to the limit when it would go past it.
   function automatic step_type debounce_step(input cnt_type cnt, input cnt_type lim);
      cnt_type  n;
      step_type r;
      n = (cnt == CNT_MAX) ? CNT_MAX : cnt + cnt_type'(1);
      if (n > lim) begin
         r.cnt  = lim;
         r.fire = 1'b0;
      end else begin
         r.cnt  = n;
         r.fire = (n == lim);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/svwd_eval.sv =====
// ----------------------------------------------------------------------------
// svwd_eval
// Debounce counters and per-sample window evaluation. Counters advance on
// each beat that moves from the input register to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module svwd_eval (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 step,
   input  svwd_pkg::req_type   item,
   input  svwd_pkg::cfg_type   cfg,
   output svwd_pkg::rsp_type   result
);
   import svwd_pkg::*;

   cnt_type over_set_ff,  over_set_in;
   cnt_type over_rel_ff,  over_rel_in;
   cnt_type under_set_ff, under_set_in;
   cnt_type under_rel_ff, under_rel_in;

   // Checks run in order; each sees the counters left by the one before it
   always_comb begin
      step_type   st_os, st_ur, st_or, st_ur2, st_us;
      report_type orep, urep;
      event_type  oev, uev;
      cnt_type    os, orl, us, url;

      os   = over_set_ff;
      orl  = over_rel_ff;
      us   = under_set_ff;
      url  = under_rel_ff;
      orep = REP_NONE;
      urep = REP_NONE;
      oev  = EV_NONE;
      uev  = EV_NONE;
      st_os  = '0;
      st_ur  = '0;
      st_or  = '0;
      st_ur2 = '0;
      st_us  = '0;

      if (item.command || !item.monitor_enable) begin
         os = '0;
         us = '0;
      end else begin
         if (item.sample > cfg.over_threshold) begin
            // overvoltage set, then undervoltage release
            st_os = debounce_step(os, cfg.over_count);
            os    = st_os.cnt;
            if (st_os.fire) begin
               oev  = EV_ENTERED;
               uev  = EV_LEFT;
               orl  = '0;
               orep = REP_FAILED;
            end
            st_ur = debounce_step(url, cfg.under_count);
            url   = st_ur.cnt;
            if (st_ur.fire) begin
               uev  = EV_LEFT;
               us   = '0;
               urep = REP_PASSED;
            end
         end else begin
            // overvoltage release
            if (item.sample <= cfg.over_release) begin
               st_or = debounce_step(orl, cfg.over_count);
               orl   = st_or.cnt;
               if (st_or.fire) begin
                  oev  = EV_LEFT;
                  os   = '0;
                  orep = REP_PASSED;
               end
            end
            // undervoltage release
            if (item.sample >= cfg.under_release) begin
               st_ur2 = debounce_step(url, cfg.under_count);
               url    = st_ur2.cnt;
               if (st_ur2.fire) begin
                  uev  = EV_LEFT;
                  us   = '0;
                  urep = REP_PASSED;
               end
            end
            // undervoltage set
            if (item.sample < cfg.under_threshold) begin
               st_us = debounce_step(us, cfg.under_count);
               us    = st_us.cnt;
               if (st_us.fire) begin
                  uev  = EV_ENTERED;
                  url  = '0;
                  urep = REP_FAILED;
               end
            end
         end
         // active trouble code with an idle set counter reports passed
         if (item.under_fault_active && (us == '0)) begin
            urep = REP_PASSED;
         end
         if (item.over_fault_active && (os == '0)) begin
            orep = REP_PASSED;
         end
      end

      over_set_in  = os;
      over_rel_in  = orl;
      under_set_in = us;
      under_rel_in = url;

      result.over_report  = orep;
      result.under_report = urep;
      result.over_event   = oev;
      result.under_event  = uev;
   end

   // Counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         over_set_ff  <= '0;
         over_rel_ff  <= '0;
         under_set_ff <= '0;
         under_rel_ff <= '0;
      end else if (step) begin
         over_set_ff  <= over_set_in;
         over_rel_ff  <= over_rel_in;
         under_set_ff <= under_set_in;
         under_rel_ff <= under_rel_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/supply_voltage_window_debounce_unit.sv =====
// ----------------------------------------------------------------------------
// supply_voltage_window_debounce_unit
// Debounced overvoltage / undervoltage monitor for one supply channel.
// ----------------------------------------------------------------------------
// Path: an accepted request beat is held in the input register, evaluated
//   combinationally, and loaded into the result register that drives rsp.
// Throughput: one beat per cycle while rsp does not stall; req_ready follows
//   rsp_ready combinationally, and the counters update on each advancing beat.
// Reset: synchronous; counters clear to zero, registers load their defaults,
//   both pipeline stages empty.
`default_nettype none

module supply_voltage_window_debounce_unit (
   input  wire                      clock,
   input  wire                      reset,
   // request channel
   input  wire                      req_valid,
   output logic                     req_ready,
   input  svwd_pkg::req_type        req_payload,
   // result channel
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output svwd_pkg::rsp_type        rsp_payload,
   // configuration write channel
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  svwd_pkg::csr_idx_type    csr_index,
   input  svwd_pkg::csr_data_type   csr_wdata
);
   import svwd_pkg::*;

   cfg_type cfg_ff;
   req_type in_ff;
   logic    in_valid_ff;
   rsp_type out_ff;
   logic    out_valid_ff;
   rsp_type result;
   logic    advance;

   // Pipeline control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.over_threshold  <= RST_OVER_THRESHOLD;
         cfg_ff.over_release    <= RST_OVER_RELEASE;
         cfg_ff.under_threshold <= RST_UNDER_THRESHOLD;
         cfg_ff.under_release   <= RST_UNDER_RELEASE;
         cfg_ff.over_count      <= RST_OVER_COUNT;
         cfg_ff.under_count     <= RST_UNDER_COUNT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OVER_THRESHOLD:  cfg_ff.over_threshold  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_OVER_RELEASE:    cfg_ff.over_release    <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_UNDER_THRESHOLD: cfg_ff.under_threshold <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_UNDER_RELEASE:   cfg_ff.under_release   <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_OVER_COUNT:      cfg_ff.over_count      <= csr_wdata[CNT_BITS-1:0];
            CSR_UNDER_COUNT:     cfg_ff.under_count     <= csr_wdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   // Evaluation and counters
   svwd_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   // Clear command or monitoring off yields an all-zero result
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      advance && (in_ff.command || !in_ff.monitor_enable) |=> rsp_payload == '0)
      else $error("clear or disabled beat produced a nonzero result");

   // Entering overvoltage always comes with a failed report
   a_enter_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.over_event == EV_ENTERED)
      |-> rsp_payload.over_report == REP_FAILED)
      else $error("overvoltage entered without failed report");

   // A beat held in the input register is not dropped
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("stalled input beat lost");

endmodule

`default_nettype wire

// ===== tb/sv/svwd_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// svwd_scoreboard_pkg
// Tracks the debounce state of the supply window monitor beat by beat, queues
// the result each request beat should produce and checks the beats that come
// back, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

package svwd_scoreboard_pkg;

   import svwd_pkg::*;

   class window_scoreboard;

      cfg_type cfg;
      cnt_type over_set;
      cnt_type over_rel;
      cnt_type under_set;
      cnt_type under_rel;
      rsp_type expected_q[$];
      int      mismatches;
      int      matched;
      int      over_trips;
      int      under_trips;

      function new();
         cfg.over_threshold  = RST_OVER_THRESHOLD;
         cfg.over_release    = RST_OVER_RELEASE;
         cfg.under_threshold = RST_UNDER_THRESHOLD;
         cfg.under_release   = RST_UNDER_RELEASE;
         cfg.over_count      = RST_OVER_COUNT;
         cfg.under_count     = RST_UNDER_COUNT;
         over_set    = '0;
         over_rel    = '0;
         under_set   = '0;
         under_rel   = '0;
         mismatches  = 0;
         matched     = 0;
         over_trips  = 0;
         under_trips = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // mirror of one register write
      function void write_reg(csr_idx_type idx, csr_data_type data);
         case (idx)
            CSR_OVER_THRESHOLD:  cfg.over_threshold  = data[SAMPLE_BITS-1:0];
            CSR_OVER_RELEASE:    cfg.over_release    = data[SAMPLE_BITS-1:0];
            CSR_UNDER_THRESHOLD: cfg.under_threshold = data[SAMPLE_BITS-1:0];
            CSR_UNDER_RELEASE:   cfg.under_release   = data[SAMPLE_BITS-1:0];
            CSR_OVER_COUNT:      cfg.over_count      = data[CNT_BITS-1:0];
            CSR_UNDER_COUNT:     cfg.under_count     = data[CNT_BITS-1:0];
            default: ;
         endcase
      endfunction

      // one debounce tick: saturate at all ones, clamp past the limit,
      // fire only when the limit is hit exactly
      function bit tick(inout cnt_type c, input cnt_type lim);
         cnt_type nxt;
         nxt = (c == '1) ? c : c + cnt_type'(1);
         if (nxt > lim) begin
            c = lim;
            return 1'b0;
         end
         c = nxt;
         return (nxt == lim);
      endfunction

      // work out the result of one accepted request beat
      function void note_request(req_type r);
         rsp_type e;
         e.over_report  = REP_NONE;
         e.under_report = REP_NONE;
         e.over_event   = EV_NONE;
         e.under_event  = EV_NONE;
         if (r.command || !r.monitor_enable) begin
            over_set  = '0;
            under_set = '0;
         end else begin
            if (r.sample > cfg.over_threshold) begin
               if (tick(over_set, cfg.over_count)) begin
                  e.over_event  = EV_ENTERED;
                  e.under_event = EV_LEFT;
                  e.over_report = REP_FAILED;
                  over_rel      = '0;
                  over_trips++;
               end
               if (tick(under_rel, cfg.under_count)) begin
                  e.under_event  = EV_LEFT;
                  e.under_report = REP_PASSED;
                  under_set      = '0;
               end
            end else begin
               if (r.sample <= cfg.over_release) begin
                  if (tick(over_rel, cfg.over_count)) begin
                     e.over_event  = EV_LEFT;
                     e.over_report = REP_PASSED;
                     over_set      = '0;
                  end
               end
               if (r.sample >= cfg.under_release) begin
                  if (tick(under_rel, cfg.under_count)) begin
                     e.under_event  = EV_LEFT;
                     e.under_report = REP_PASSED;
                     under_set      = '0;
                  end
               end
               if (r.sample < cfg.under_threshold) begin
                  if (tick(under_set, cfg.under_count)) begin
                     e.under_event  = EV_ENTERED;
                     e.under_report = REP_FAILED;
                     under_rel      = '0;
                     under_trips++;
                  end
               end
            end
            // an active trouble code with a quiet set counter reports passed
            if (r.under_fault_active && under_set == '0)
               e.under_report = REP_PASSED;
            if (r.over_fault_active && over_set == '0)
               e.over_report = REP_PASSED;
         end
         expected_q.push_back(e);
      endfunction

      // compare one accepted result beat with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: result beat with nothing expected: expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         if (got.over_report !== e.over_report || got.under_report !== e.under_report ||
             got.over_event !== e.over_event || got.under_event !== e.under_event) begin
            $display("%0t: result mismatch: expected orep=%0d urep=%0d oev=%0d uev=%0d",
                     $time, e.over_report, e.under_report, e.over_event, e.under_event);
            $display("%0t:                  actual   orep=%0d urep=%0d oev=%0d uev=%0d",
                     $time, got.over_report, got.under_report, got.over_event,
                     got.under_event);
            mismatches++;
         end else begin
            matched++;
         end
      endfunction

   endclass

endpackage

`default_nettype wire

// ===== tb/sv/supply_voltage_window_debounce_unit_tb.sv =====
// ----------------------------------------------------------------------------
// supply_voltage_window_debounce_unit_tb
// Drives request beats through the window monitor under a series of register
// settings (defaults, fastest and slowest counts, saturating counts, fully
// misordered thresholds and random windows), with random stalls on both
// channels, and checks every result beat against a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module supply_voltage_window_debounce_unit_tb;

   import svwd_pkg::*;
   import svwd_scoreboard_pkg::*;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_type      req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_type      rsp_payload;
   logic         csr_valid   = 1'b0;
   logic         csr_ready;
   csr_idx_type  csr_index   = '0;
   csr_data_type csr_wdata   = '0;

   window_scoreboard sb = new();
   bit steady = 1'b0;   // no idling on either side while set
   int sent = 0;
   int settings = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   supply_voltage_window_debounce_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // run limit
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // result side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_payload);
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
   end

   function automatic req_type make_req(bit cmd, int s, bit en, bit ua, bit oa);
      req_type r;
      r.command            = cmd;
      r.sample             = sample_type'(s);
      r.monitor_enable     = en;
      r.under_fault_active = ua;
      r.over_fault_active  = oa;
      return r;
   endfunction

   // one request beat; valid stays high for the next beat unless it idles
   task automatic push_item(input req_type r);
      int gap;
      gap = (!steady && $urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input int data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= csr_data_type'(data);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, csr_data_type'(data));
   endtask

   // full register set, written only with the block drained
   task automatic configure(input int ot, input int orl, input int ut, input int url,
                            input int oc, input int uc);
      settle();
      write_reg(CSR_OVER_THRESHOLD, ot);
      write_reg(CSR_OVER_RELEASE, orl);
      write_reg(CSR_UNDER_THRESHOLD, ut);
      write_reg(CSR_UNDER_RELEASE, url);
      write_reg(CSR_OVER_COUNT, oc);
      write_reg(CSR_UNDER_COUNT, uc);
      csr_valid <= 1'b0;
      settings++;
   endtask

   // level for a run: extremes, the four boundaries, their neighbors or a random value
   function automatic sample_type pick_level();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return sb.cfg.over_threshold;
         3:       return sb.cfg.over_threshold + sample_type'(1);
         4:       return sb.cfg.over_release;
         5:       return sb.cfg.over_release + sample_type'(1);
         6:       return sb.cfg.under_threshold;
         7:       return sb.cfg.under_threshold - sample_type'(1);
         8:       return sb.cfg.under_release;
         9:       return sb.cfg.under_release - sample_type'(1);
         default: return sample_type'($urandom_range(0, 4095));
      endcase
   endfunction

   // runs of samples near one level with occasional clears, monitoring
   // gaps and stray samples breaking them up
   task automatic run_phase(input int n, input int run_max);
      int         left;
      int         len;
      sample_type center;
      req_type    r;
      left = n;
      while (left > 0) begin
         len = $urandom_range(1, run_max);
         if (len > left)
            len = left;
         center = pick_level();
         repeat (len) begin
            r.command            = ($urandom_range(0, 99) < 3);
            r.monitor_enable     = ($urandom_range(0, 99) < 93);
            r.under_fault_active = ($urandom_range(0, 1) == 1);
            r.over_fault_active  = ($urandom_range(0, 1) == 1);
            case ($urandom_range(0, 9))
               0:       r.sample = sample_type'($urandom_range(0, 4095));
               1:       r.sample = center + sample_type'($urandom_range(0, 6))
                                   - sample_type'(3);
               default: r.sample = center;
            endcase
            push_item(r);
            left--;
         end
      end
   endtask

   // clean run at one level, long enough to saturate the counters
   task automatic hold_level(input int s, input int len);
      repeat (len)
         push_item(make_req(1'b0, s, 1'b1, ($urandom_range(0, 1) == 1),
                            ($urandom_range(0, 1) == 1)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: short counts so every fire shows in a few beats
      configure(3500, 3300, 1500, 1700, 2, 2);
      push_item(make_req(1'b0, 4095, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 4095, 1'b1, 1'b0, 1'b0));   // over set, under release
      push_item(make_req(1'b0, 4095, 1'b1, 1'b0, 1'b1));   // clamped, no fire
      push_item(make_req(1'b0, 0, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 0, 1'b1, 1'b1, 1'b0));      // over release, under set
      push_item(make_req(1'b1, 4095, 1'b1, 1'b1, 1'b1));   // clear command
      push_item(make_req(1'b0, 4095, 1'b0, 1'b1, 1'b1));   // monitoring off
      push_item(make_req(1'b0, 2000, 1'b1, 1'b1, 1'b1));   // both codes passed
      push_item(make_req(1'b0, 3500, 1'b1, 1'b0, 1'b0));   // at over threshold
      push_item(make_req(1'b0, 3501, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 3501, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 3300, 1'b1, 1'b0, 1'b0));   // at over release
      push_item(make_req(1'b0, 3301, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 3300, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 1500, 1'b1, 1'b0, 1'b0));   // at under threshold
      push_item(make_req(1'b0, 1499, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 1499, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 1699, 1'b1, 1'b0, 1'b0));
      push_item(make_req(1'b0, 1700, 1'b1, 1'b0, 1'b0));   // at under release
      push_item(make_req(1'b0, 1700, 1'b1, 1'b1, 1'b0));

      // random part
      configure(3500, 3300, 1500, 1700, 10, 10);
      run_phase(200, 24);
      configure(3500, 3300, 1500, 1700, 1, 1);
      run_phase(120, 6);
      // empty windows, count of zero never fires, slowest count
      configure(4095, 0, 0, 4095, 0, 254);
      run_phase(80, 30);
      // fully misordered thresholds: several checks fire on one sample
      configure(0, 4095, 4095, 0, 3, 2);
      run_phase(160, 10);

      // saturating counts, with neither side idling
      configure(3500, 3300, 1500, 1700, 255, 255);
      steady = 1'b1;
      hold_level(4095, 260);
      hold_level(0, 260);
      run_phase(60, 20);
      steady = 1'b0;

      repeat (3) begin
         configure($urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(1, 8), $urandom_range(1, 8));
         run_phase(60, 12);
      end

      settle();
      repeat (4) @(posedge clock);
      $display("summary: %0d request beats under %0d register settings, %0d results matched",
               sent, settings, sb.matched);
      $display("summary: %0d overvoltage and %0d undervoltage trips seen",
               sb.over_trips, sb.under_trips);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/svwd_pkg.sv
rtl/svwd_eval.sv
rtl/supply_voltage_window_debounce_unit.sv
tb/sv/svwd_scoreboard_pkg.sv
tb/sv/supply_voltage_window_debounce_unit_tb.sv
